/* sv/lgcu_pkg.sv */
// shared kinds, stage word types and the three-level rule
`default_nettype none
package lgcu_pkg;

    localparam logic [4:0] K_AIR     = 5'd0;
    localparam logic [4:0] K_WIRE    = 5'd1;
    localparam logic [4:0] K_OUTPUT  = 5'd2;
    localparam logic [4:0] K_BATTERY = 5'd3;
    localparam logic [4:0] K_DELAY   = 5'd4;
    localparam logic [4:0] K_BRIDGE  = 5'd5;
    localparam logic [4:0] K_LAMP    = 5'd6;
    localparam logic [4:0] K_BUTTON  = 5'd7;
    localparam logic [4:0] K_SWITCH  = 5'd8;
    localparam logic [4:0] K_NOT     = 5'd9;
    localparam logic [4:0] K_OR      = 5'd10;
    localparam logic [4:0] K_NOR     = 5'd11;
    localparam logic [4:0] K_XOR     = 5'd12;
    localparam logic [4:0] K_XNOR    = 5'd13;
    localparam logic [4:0] K_AND     = 5'd14;
    localparam logic [4:0] K_NAND    = 5'd15;
    localparam logic [4:0] K_CLOCK   = 5'd16;
    localparam logic [4:0] K_DEBUG   = 5'd17;

    localparam logic [1:0] SEEN_OFF = 2'b01;
    localparam logic [1:0] SEEN_ON  = 2'b10;

    localparam logic [7:0] LVL_OFF     = 8'd0;
    localparam logic [7:0] LVL_NEUTRAL = 8'd1;
    localparam logic [7:0] LVL_ON      = 8'd2;

    // neighbour flags, first stage
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] lv;
        logic [7:0] lv2;
        logic [7:0] tm;
        logic [7:0] step;
        logic [1:0] vseen;
        logic [1:0] hseen;
        logic [3:0] gin;
        logic [3:0] pwr;
        logic       any_on;
        logic       any_off;
        logic       out_on;
    } sense_t;

    // next bytes, second stage
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] lv;
        logic [7:0] lv2;
        logic [7:0] tm;
        logic [7:0] nl;
        logic [7:0] nl2;
        logic [7:0] nt;
        logic       hit;
    } rule_t;

    function automatic logic [7:0] tri_next(input logic [7:0] lv, input logic [1:0] seen);
        logic [7:0] r;
        r = lv;
        if (lv == LVL_OFF)
            r = LVL_NEUTRAL;
        else if (lv == LVL_ON && (seen & SEEN_OFF) != 2'b00)
            r = LVL_OFF;
        else if (lv == LVL_NEUTRAL && (seen & SEEN_ON) != 2'b00)
            r = LVL_ON;
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/lgcu_sense.sv */
// stage one: per-neighbour level sensing, gate inputs and kind matches
`default_nettype none
module lgcu_sense (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [4:0]      cell_type,
    input  wire logic [7:0]      cell_level,
    input  wire logic [7:0]      cell_level2,
    input  wire logic [7:0]      cell_timer,
    input  wire logic [23:0]     up_cell,
    input  wire logic [23:0]     down_cell,
    input  wire logic [23:0]     left_cell,
    input  wire logic [23:0]     right_cell,
    input  wire logic [7:0]      time_step,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lgcu_pkg::sense_t     out_word
);
    import lgcu_pkg::*;

    logic        valid_reg;
    sense_t      word_reg;
    sense_t      word_next;
    logic [23:0] nb [4];

    function automatic logic conducting(input logic [7:0] k);
        return (k != 8'd0) && (k <= {3'b000, K_BRIDGE});
    endfunction

    function automatic logic [7:0] nb_level(input logic [23:0] c, input logic vertical);
        return (vertical && c[23:16] == {3'b000, K_BRIDGE}) ? c[7:0] : c[15:8];
    endfunction

    function automatic logic [1:0] seen_bits(input logic [7:0] lv);
        logic [1:0] r;
        r = 2'b00;
        if (lv == LVL_OFF)
            r = SEEN_OFF;
        else if (lv == LVL_ON)
            r = SEEN_ON;
        return r;
    endfunction

    function automatic logic [1:0] sense(input logic [23:0] c, input logic vertical,
                                         input logic lamp_ok);
        logic [1:0] r;
        r = 2'b00;
        if (conducting(c[23:16]))
            r = seen_bits(nb_level(c, vertical));
        else if (lamp_ok && c[23:16] == {3'b000, K_LAMP})
            r = seen_bits(c[15:8]);
        return r;
    endfunction

    assign nb[0] = up_cell;
    assign nb[1] = down_cell;
    assign nb[2] = left_cell;
    assign nb[3] = right_cell;

    always_comb
    begin
        word_next.kind  = cell_type;
        word_next.lv    = cell_level;
        word_next.lv2   = cell_level2;
        word_next.tm    = cell_timer;
        word_next.step  = time_step;
        word_next.vseen = sense(up_cell, 1'b1, cell_type == K_LAMP)
                        | sense(down_cell, 1'b1, cell_type == K_LAMP);
        word_next.hseen = sense(left_cell, 1'b0, cell_type == K_LAMP)
                        | sense(right_cell, 1'b0, cell_type == K_LAMP);
        word_next.any_on  = 1'b0;
        word_next.any_off = 1'b0;
        word_next.out_on  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            word_next.gin[i] = conducting(nb[i][23:16])
                             && nb[i][23:16] != {3'b000, K_OUTPUT};
            word_next.pwr[i] = word_next.gin[i] && nb_level(nb[i], i < 2) == LVL_ON;
            if (nb[i][23:16] == {3'b000, cell_type} && nb[i][15:8] > LVL_NEUTRAL)
                word_next.any_on = 1'b1;
            if (nb[i][23:16] == {3'b000, cell_type} && nb[i][15:8] == LVL_OFF)
                word_next.any_off = 1'b1;
            // output cells follow any button-or-higher kind that is on
            if (nb[i][23:16] >= {3'b000, K_BUTTON} && nb[i][15:8] > LVL_NEUTRAL)
                word_next.out_on = 1'b1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

/* sv/lgcu_rule.sv */
// stage two: next-state rules per cell kind
`default_nettype none
module lgcu_rule (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lgcu_pkg::sense_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lgcu_pkg::rule_t       out_word
);
    import lgcu_pkg::*;

    logic       valid_reg;
    rule_t      word_reg;
    rule_t      word_next;
    logic [2:0] pow;
    logic [1:0] seen;
    logic [7:0] cnt_left;

    assign pow = {2'b00, in_word.pwr[0]} + {2'b00, in_word.pwr[1]}
               + {2'b00, in_word.pwr[2]} + {2'b00, in_word.pwr[3]};
    assign seen = in_word.vseen | in_word.hseen;
    assign cnt_left = (in_word.tm > in_word.step) ? in_word.tm - in_word.step : 8'd0;

    always_comb
    begin
        word_next.kind = in_word.kind;
        word_next.lv   = in_word.lv;
        word_next.lv2  = in_word.lv2;
        word_next.tm   = in_word.tm;
        word_next.nl   = in_word.lv;
        word_next.nl2  = in_word.lv2;
        word_next.nt   = in_word.tm;
        word_next.hit  = 1'b0;
        case (in_word.kind)
            K_WIRE, K_LAMP:
                word_next.nl = tri_next(in_word.lv, seen);
            K_OUTPUT:
                word_next.nl = in_word.out_on ? LVL_ON : LVL_OFF;
            K_DELAY:
            begin
                if (in_word.lv == LVL_OFF)
                    word_next.nl = LVL_NEUTRAL;
                else if (in_word.lv > LVL_NEUTRAL)
                begin
                    if ((seen & SEEN_OFF) != 2'b00)
                        word_next.nl = LVL_OFF;
                    else if (in_word.lv > LVL_ON)
                        word_next.nl = in_word.lv - 8'd1;
                end
                else if ((seen & SEEN_ON) != 2'b00)
                    word_next.nl = in_word.lv2;
            end
            K_BRIDGE:
            begin
                word_next.nl2 = tri_next(in_word.lv2, in_word.vseen);
                word_next.nl  = tri_next(in_word.lv, in_word.hseen);
            end
            K_BUTTON:
            begin
                if (in_word.lv == LVL_OFF)
                    word_next.nl = LVL_NEUTRAL;
                else if (in_word.lv == LVL_ON)
                    word_next.nl = LVL_OFF;
                else if (in_word.any_on)
                    word_next.nl = LVL_ON;
            end
            K_SWITCH:
            begin
                if (in_word.lv == LVL_OFF)
                    word_next.nl = LVL_NEUTRAL;
                else if (in_word.lv == LVL_ON && in_word.any_off)
                    word_next.nl = LVL_OFF;
                else if (in_word.any_on)
                    word_next.nl = LVL_ON;
            end
            K_NOT:  word_next.nl = (pow != 3'd0) ? LVL_OFF : LVL_ON;
            K_OR:   word_next.nl = (pow != 3'd0) ? LVL_ON : LVL_OFF;
            K_NOR:  word_next.nl = (pow == 3'd0) ? LVL_ON : LVL_OFF;
            K_XOR:  word_next.nl = (pow == 3'd1) ? LVL_ON : LVL_OFF;
            K_XNOR: word_next.nl = (pow != 3'd1) ? LVL_ON : LVL_OFF;
            // powered inputs are a subset of inputs, so all-powered is an equality
            K_AND:  word_next.nl = (in_word.pwr == in_word.gin) ? LVL_ON : LVL_OFF;
            K_NAND: word_next.nl = (in_word.pwr != in_word.gin) ? LVL_ON : LVL_OFF;
            K_CLOCK:
            begin
                if (cnt_left == 8'd0)
                begin
                    word_next.nl = LVL_ON;
                    word_next.nt = in_word.lv2;
                end
                else
                begin
                    word_next.nl = LVL_OFF;
                    word_next.nt = cnt_left;
                end
            end
            K_DEBUG:
                word_next.hit = (pow != 3'd0);
            default:
                word_next.nl = in_word.lv;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

/* sv/lgcu_result.sv */
// stage three: changed flag and output register
`default_nettype none
module lgcu_result (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lgcu_pkg::rule_t in_word,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           new_level,
    output logic [7:0]           new_level2,
    output logic [7:0]           new_timer,
    output logic                 changed,
    output logic                 debug_hit
);
    import lgcu_pkg::*;

    logic       valid_reg;
    logic [7:0] level_reg;
    logic [7:0] level2_reg;
    logic [7:0] timer_reg;
    logic       changed_reg;
    logic       hit_reg;
    logic       changed_next;

    always_comb
    begin
        if (in_word.kind == K_CLOCK)
            changed_next = 1'b1;
        else if (in_word.kind == K_DEBUG)
            changed_next = in_word.hit;
        else
            changed_next = (in_word.nl != in_word.lv) || (in_word.nl2 != in_word.lv2)
                         || (in_word.nt != in_word.tm);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg   <= in_word.nl;
            level2_reg  <= in_word.nl2;
            timer_reg   <= in_word.nt;
            changed_reg <= changed_next;
            hit_reg     <= in_word.hit;
        end
    end

    assign out_valid  = valid_reg;
    assign new_level  = level_reg;
    assign new_level2 = level2_reg;
    assign new_timer  = timer_reg;
    assign changed    = changed_reg;
    assign debug_hit  = hit_reg;

endmodule
`default_nettype wire

/* sv/logic_grid_cell_update_unit.sv */
// top level of the logic grid cell update unit
// Next-state unit for one cell of a logic-circuit grid automaton. It takes one cell
// word per clock while in_ready is high (kind, three state bytes, four packed
// neighbours and the frame's clock decrement) and returns its next three bytes with a
// changed flag and a debug hit flag. The unit is a three-stage pipeline (neighbour
// sensing, per-kind rule, changed flag into the output register), and the sustained
// rate is one word per cycle while the output is taken. Every stage has its own
// valid bit; in_ready drops only when all three stages are full and the output is
// not taken, so no word is dropped or repeated under backpressure.
`default_nettype none
module logic_grid_cell_update_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [4:0]  cell_type,
    input  wire logic [7:0]  cell_level,
    input  wire logic [7:0]  cell_level2,
    input  wire logic [7:0]  cell_timer,
    input  wire logic [23:0] up_cell,
    input  wire logic [23:0] down_cell,
    input  wire logic [23:0] left_cell,
    input  wire logic [23:0] right_cell,
    input  wire logic [7:0]  time_step,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       new_level,
    output logic [7:0]       new_level2,
    output logic [7:0]       new_timer,
    output logic             changed,
    output logic             debug_hit
);
    import lgcu_pkg::*;

    logic   s1_valid;
    logic   s1_ready;
    sense_t s1_word;
    logic   s2_valid;
    logic   s2_ready;
    rule_t  s2_word;

    lgcu_sense u_sense (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cell_type   (cell_type),
        .cell_level  (cell_level),
        .cell_level2 (cell_level2),
        .cell_timer  (cell_timer),
        .up_cell     (up_cell),
        .down_cell   (down_cell),
        .left_cell   (left_cell),
        .right_cell  (right_cell),
        .time_step   (time_step),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_word    (s1_word)
    );

    lgcu_rule u_rule (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    lgcu_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_word    (s2_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_level  (new_level),
        .new_level2 (new_level2),
        .new_timer  (new_timer),
        .changed    (changed),
        .debug_hit  (debug_hit)
    );

    // input stalls only with every stage full and the output held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid && s2_valid && out_valid && !out_ready))
        else $error("input stalled with a free pipeline slot");

    // a debug hit always marks the word as changed
    a_hit_implies_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && debug_hit) |-> changed)
        else $error("debug hit without changed flag");

    // a word in the middle stage never vanishes while the output is stalled
    a_mid_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && out_valid && !out_ready) |=> s2_valid)
        else $error("middle stage word lost under stall");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the logic grid cell update unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lgcu_pkg::*;

    localparam int PLAN_RANDOM = 900;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  level;
        logic [7:0]  level2;
        logic [7:0]  timer;
        logic [23:0] up_nb;
        logic [23:0] down_nb;
        logic [23:0] left_nb;
        logic [23:0] right_nb;
        logic [7:0]  tstep;
    } cell_word_t;

    typedef struct packed {
        logic [7:0] nl;
        logic [7:0] nl2;
        logic [7:0] nt;
        logic       chg;
        logic       hit;
    } cell_next_t;

    class cell_scoreboard;
        cell_next_t expected_q[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        function logic [1:0] level_flags(logic [7:0] lv);
            if (lv == LVL_OFF)
                return SEEN_OFF;
            if (lv == LVL_ON)
                return SEEN_ON;
            return 2'b00;
        endfunction

        // bridge above or below presents its vertical byte
        function logic [7:0] nb_level(logic [23:0] nb, bit vertical);
            if (vertical && nb[23:16] == K_BRIDGE)
                return nb[7:0];
            return nb[15:8];
        endfunction

        function logic [1:0] nb_flags(logic [23:0] nb, bit vertical, bit lamp_ok);
            if (nb[23:16] > K_AIR && nb[23:16] <= K_BRIDGE)
                return level_flags(nb_level(nb, vertical));
            if (lamp_ok && nb[23:16] == K_LAMP)
                return level_flags(nb[15:8]);
            return 2'b00;
        endfunction

        function logic [7:0] three_level(logic [7:0] lv, logic [1:0] seen);
            if (lv == LVL_OFF)
                return LVL_NEUTRAL;
            if (lv == LVL_ON && (seen & SEEN_OFF) != 2'b00)
                return LVL_OFF;
            if (lv == LVL_NEUTRAL && (seen & SEEN_ON) != 2'b00)
                return LVL_ON;
            return lv;
        endfunction

        function cell_next_t next_state(cell_word_t w);
            logic [23:0] nbs [4];
            logic [1:0]  vseen;
            logic [1:0]  hseen;
            logic [1:0]  seen;
            logic [7:0]  k;
            int unsigned pow;
            int unsigned cnt;
            bit          any_on;
            bit          any_off;
            bit          lamp_ok;
            int          i;
            cell_next_t  r;
            nbs[0] = w.up_nb;
            nbs[1] = w.down_nb;
            nbs[2] = w.left_nb;
            nbs[3] = w.right_nb;
            lamp_ok = (w.kind == K_LAMP);
            vseen = nb_flags(nbs[0], 1'b1, lamp_ok) | nb_flags(nbs[1], 1'b1, lamp_ok);
            hseen = nb_flags(nbs[2], 1'b0, lamp_ok) | nb_flags(nbs[3], 1'b0, lamp_ok);
            seen = vseen | hseen;
            pow = 0;
            cnt = 0;
            any_on = 1'b0;
            any_off = 1'b0;
            for (i = 0; i < 4; i++)
            begin
                k = nbs[i][23:16];
                // output cells never drive a gate
                if (k > K_AIR && k <= K_BRIDGE && k != K_OUTPUT)
                begin
                    cnt++;
                    if (nb_level(nbs[i], i < 2) == LVL_ON)
                        pow++;
                end
                if (k == {3'b000, w.kind} && nbs[i][15:8] > LVL_NEUTRAL)
                    any_on = 1'b1;
                if (k == {3'b000, w.kind} && nbs[i][15:8] == LVL_OFF)
                    any_off = 1'b1;
            end
            r.nl = w.level;
            r.nl2 = w.level2;
            r.nt = w.timer;
            r.hit = 1'b0;
            case (w.kind)
                K_WIRE, K_LAMP: r.nl = three_level(w.level, seen);
                K_OUTPUT:
                begin
                    r.nl = LVL_OFF;
                    for (i = 0; i < 4; i++)
                        if (nbs[i][23:16] >= K_BUTTON && nbs[i][15:8] > LVL_NEUTRAL)
                            r.nl = LVL_ON;
                end
                K_DELAY:
                begin
                    if (w.level == LVL_OFF)
                        r.nl = LVL_NEUTRAL;
                    else if (w.level > LVL_NEUTRAL)
                    begin
                        if ((seen & SEEN_OFF) != 2'b00)
                            r.nl = LVL_OFF;
                        else if (w.level > LVL_ON)
                            r.nl = w.level - 8'd1;
                    end
                    else if ((seen & SEEN_ON) != 2'b00)
                        r.nl = w.level2;
                end
                K_BRIDGE:
                begin
                    r.nl2 = three_level(w.level2, vseen);
                    r.nl = three_level(w.level, hseen);
                end
                K_BUTTON:
                begin
                    if (w.level == LVL_OFF)
                        r.nl = LVL_NEUTRAL;
                    else if (w.level == LVL_ON)
                        r.nl = LVL_OFF;
                    else if (any_on)
                        r.nl = LVL_ON;
                end
                K_SWITCH:
                begin
                    if (w.level == LVL_OFF)
                        r.nl = LVL_NEUTRAL;
                    else if (w.level == LVL_ON && any_off)
                        r.nl = LVL_OFF;
                    else if (any_on)
                        r.nl = LVL_ON;
                end
                K_NOT:  r.nl = (pow > 0) ? LVL_OFF : LVL_ON;
                K_OR:   r.nl = (pow > 0) ? LVL_ON : LVL_OFF;
                K_NOR:  r.nl = (pow == 0) ? LVL_ON : LVL_OFF;
                K_XOR:  r.nl = (pow == 1) ? LVL_ON : LVL_OFF;
                K_XNOR: r.nl = (pow != 1) ? LVL_ON : LVL_OFF;
                K_AND:  r.nl = (pow == cnt) ? LVL_ON : LVL_OFF;
                K_NAND: r.nl = (pow != cnt) ? LVL_ON : LVL_OFF;
                K_CLOCK:
                begin
                    // countdown saturates at zero, then reloads
                    if (w.timer > w.tstep)
                    begin
                        r.nt = w.timer - w.tstep;
                        r.nl = LVL_OFF;
                    end
                    else
                    begin
                        r.nt = w.level2;
                        r.nl = LVL_ON;
                    end
                end
                K_DEBUG: r.hit = (pow > 0);
                default: ;
            endcase
            r.chg = (r.nl != w.level) || (r.nl2 != w.level2) || (r.nt != w.timer);
            if (w.kind == K_CLOCK)
                r.chg = 1'b1;
            if (w.kind == K_DEBUG)
                r.chg = r.hit;
            return r;
        endfunction

        function void note_word(cell_word_t w);
            expected_q.push_back(next_state(w));
        endfunction

        function void check_word(cell_next_t got);
            cell_next_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word with no input word pending");
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.nl !== want.nl)
            begin
                $error("new_level: expected %0d, actual %0d", want.nl, got.nl);
                failures++;
            end
            if (got.nl2 !== want.nl2)
            begin
                $error("new_level2: expected %0d, actual %0d", want.nl2, got.nl2);
                failures++;
            end
            if (got.nt !== want.nt)
            begin
                $error("new_timer: expected %0d, actual %0d", want.nt, got.nt);
                failures++;
            end
            if (got.chg !== want.chg)
            begin
                $error("changed: expected %0d, actual %0d", want.chg, got.chg);
                failures++;
            end
            if (got.hit !== want.hit)
            begin
                $error("debug_hit: expected %0d, actual %0d", want.hit, got.hit);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       out_ready = 1'b0;
    cell_word_t drive_w = '0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] new_level;
    logic [7:0] new_level2;
    logic [7:0] new_timer;
    logic       changed;
    logic       debug_hit;

    cell_scoreboard sb = new();
    cell_word_t     plan[$];
    int             idle_cycles = 0;
    int             rx_mode = 0;
    int             rx_left = 0;
    int             rx_count = 0;

    logic_grid_cell_update_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cell_type   (drive_w.kind),
        .cell_level  (drive_w.level),
        .cell_level2 (drive_w.level2),
        .cell_timer  (drive_w.timer),
        .up_cell     (drive_w.up_nb),
        .down_cell   (drive_w.down_nb),
        .left_cell   (drive_w.left_nb),
        .right_cell  (drive_w.right_nb),
        .time_step   (drive_w.tstep),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_level   (new_level),
        .new_level2  (new_level2),
        .new_timer   (new_timer),
        .changed     (changed),
        .debug_hit   (debug_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [23:0] nbw(logic [7:0] kind, logic [7:0] b1, logic [7:0] b2);
        return {kind, b1, b2};
    endfunction

    function automatic cell_word_t mk(logic [4:0] kind, logic [7:0] lv, logic [7:0] lv2,
                                      logic [7:0] tm, logic [23:0] up, logic [23:0] dn,
                                      logic [23:0] lf, logic [23:0] rt, logic [7:0] st);
        cell_word_t w;
        w.kind = kind;
        w.level = lv;
        w.level2 = lv2;
        w.timer = tm;
        w.up_nb = up;
        w.down_nb = dn;
        w.left_nb = lf;
        w.right_nb = rt;
        w.tstep = st;
        return w;
    endfunction

    // neighbours mostly take low levels so the rules see off, neutral and on
    function automatic logic [23:0] rand_nb(logic [4:0] own_kind);
        int         r;
        logic [7:0] k;
        logic [7:0] b1;
        logic [7:0] b2;
        r = $urandom_range(0, 11);
        if (r == 0)
            return 24'($urandom_range(0, 24'hFFFFFF));
        if (r < 4)
            k = {3'b000, own_kind};
        else if (r < 11)
            k = 8'($urandom_range(0, 17));
        else
            k = 8'($urandom_range(18, 255));
        b1 = 8'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255));
        b2 = 8'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255));
        return {k, b1, b2};
    endfunction

    function automatic cell_word_t rand_word();
        cell_word_t w;
        int         r;
        r = $urandom_range(0, 19);
        w.kind = 5'((r < 18) ? r : $urandom_range(18, 31));
        w.level = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 255));
        w.level2 = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
        w.timer = 8'($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255));
        w.tstep = 8'($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255));
        w.up_nb = rand_nb(w.kind);
        w.down_nb = rand_nb(w.kind);
        w.left_nb = rand_nb(w.kind);
        w.right_nb = rand_nb(w.kind);
        return w;
    endfunction

    task automatic build_plan();
        int i;
        plan.push_back(mk(K_AIR, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_BATTERY, 255, 255, 255, '1, '1, '1, '1, 255));
        plan.push_back(mk(5'd31, 2, 7, 9, nbw(8'(K_WIRE), 2, 0), nbw(8'(K_LAMP), 0, 0),
                          0, 0, 4));
        plan.push_back(mk(K_WIRE, 2, 0, 0, 0, 0, nbw(8'(K_WIRE), 0, 9), 0, 0));
        // vertical bridge neighbour gives its second byte
        plan.push_back(mk(K_WIRE, 1, 0, 0, nbw(8'(K_BRIDGE), 0, 2), 0, 0, 0, 0));
        plan.push_back(mk(K_LAMP, 1, 0, 0, 0, 0, nbw(8'(K_LAMP), 2, 0), 0, 0));
        plan.push_back(mk(K_WIRE, 1, 0, 0, 0, 0, nbw(8'(K_LAMP), 2, 0), 0, 0));
        plan.push_back(mk(K_OUTPUT, 0, 0, 0, 0, 0, 0, nbw(8'd200, 5, 0), 0));
        plan.push_back(mk(K_OUTPUT, 2, 0, 0, nbw(8'(K_WIRE), 2, 2), 0,
                          nbw(8'(K_LAMP), 2, 0), 0, 0));
        plan.push_back(mk(K_DELAY, 0, 5, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_DELAY, 5, 3, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_DELAY, 3, 3, 0, 0, nbw(8'(K_WIRE), 0, 1), 0, 0, 0));
        plan.push_back(mk(K_DELAY, 1, 9, 0, 0, 0, 0, nbw(8'(K_BATTERY), 2, 0), 0));
        plan.push_back(mk(K_BRIDGE, 1, 2, 0, nbw(8'(K_WIRE), 0, 2), 0,
                          nbw(8'(K_WIRE), 2, 0), 0, 0));
        plan.push_back(mk(K_BUTTON, 1, 0, 0, nbw(8'(K_BUTTON), 3, 0), 0, 0, 0, 0));
        plan.push_back(mk(K_SWITCH, 2, 0, 0, 0, 0, nbw(8'(K_SWITCH), 0, 0), 0, 0));
        plan.push_back(mk(K_NOT, 2, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_OR, 0, 0, 0, 0, 0, nbw(8'(K_OUTPUT), 2, 2), 0, 0));
        plan.push_back(mk(K_NOR, 2, 0, 0, nbw(8'd30, 2, 2), 0, 0, 0, 0));
        plan.push_back(mk(K_XOR, 0, 0, 0, nbw(8'(K_WIRE), 2, 0), 0, 0, 0, 0));
        plan.push_back(mk(K_XNOR, 0, 0, 0, nbw(8'(K_WIRE), 2, 0), nbw(8'(K_DELAY), 2, 0),
                          0, 0, 0));
        plan.push_back(mk(K_AND, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_NAND, 2, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(K_CLOCK, 0, 40, 5, 0, 0, 0, 0, 9));
        plan.push_back(mk(K_CLOCK, 2, 40, 200, 0, 0, 0, 0, 3));
        plan.push_back(mk(K_DEBUG, 0, 0, 0, 0, 0, nbw(8'(K_WIRE), 2, 0), 0, 0));
        for (i = 0; i < PLAN_RANDOM; i++)
            plan.push_back(rand_word());
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(cell_word_t w);
        drive_w <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // receiver stall pattern: changes character whenever its random run length runs out
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_count % 5) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(drive_w);
            if (out_valid && out_ready)
                sb.check_word({new_level, new_level2, new_timer, changed, debug_hit});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int gap;
        int i;
        build_plan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        burst = $urandom_range(1, 12);
        for (i = 0; i < plan.size(); i++)
        begin
            send_word(plan[i]);
            burst--;
            if (burst == 0)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                // now and then a long burst with no gaps at all
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 120)
                                                    : $urandom_range(1, 12);
            end
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
